FILE: hdl/cbm_pkg.sv
// Shared types, codes and widths for the cartridge bank mapper.
package cbm_pkg;

    localparam int ROM_BANK_W     = 9;
    localparam int RAM_BANK_W     = 4;
    localparam int ROM_COUNT_W    = 10;
    localparam int RAM_COUNT_W    = 5;
    localparam int ADDR_W         = 16;
    localparam int DATA_W         = 8;
    localparam int OFFSET_W       = 23;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 10;

    localparam int DEF_MAX_ROM_BANKS = 512;
    localparam int DEF_MAX_RAM_BANKS = 16;

    // Mapper kinds.
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_SECOND = 2'd1;
    localparam logic [1:0] KIND_THIRD  = 2'd2;
    localparam logic [1:0] KIND_FIFTH  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAPPER_KIND    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_COUNT = 2'd2;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Translation targets.
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_ROM  = 2'd1;
    localparam logic [1:0] TGT_RAM  = 2'd2;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_bank_valid;
        logic                  ram_enabled;
        logic                  rom_mode;
        logic [1:0]            upper_bits;
    } t_bank_state;

endpackage

FILE: hdl/cbm_state.sv
// Banking state registers and the register write decode for all mapper kinds.
module cbm_state #(
    parameter int MAX_ROM_BANKS = cbm_pkg::DEF_MAX_ROM_BANKS,
    parameter int MAX_RAM_BANKS = cbm_pkg::DEF_MAX_RAM_BANKS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [1:0]                         i_mapper_kind,
    input  logic [cbm_pkg::ROM_COUNT_W-1:0]    i_rom_bank_count,
    input  logic [cbm_pkg::RAM_COUNT_W-1:0]    i_ram_bank_count,
    input  logic                               i_update,
    input  logic                               i_command,
    input  logic [cbm_pkg::ADDR_W-1:0]         i_cpu_address,
    input  logic [cbm_pkg::DATA_W-1:0]         i_write_data,
    output cbm_pkg::t_bank_state               o_state,
    output logic [cbm_pkg::ROM_BANK_W-1:0]     o_rom_bank_next
);
    import cbm_pkg::*;

    t_bank_state r_state;
    t_bank_state n_state;

    logic [ROM_COUNT_W-1:0] w_rom_n;
    logic [RAM_COUNT_W-1:0] w_ram_n;

    // Bank counts above the supported maxima are treated as the maxima.
    assign w_rom_n = (i_rom_bank_count > ROM_COUNT_W'(MAX_ROM_BANKS)) ?
                     ROM_COUNT_W'(MAX_ROM_BANKS) : i_rom_bank_count;
    assign w_ram_n = (i_ram_bank_count > RAM_COUNT_W'(MAX_RAM_BANKS)) ?
                     RAM_COUNT_W'(MAX_RAM_BANKS) : i_ram_bank_count;

    // A bank at or above the count is masked by count - 1. A count of zero
    // gives an all-ones mask, so the bank stays as it is.
    function automatic logic [ROM_BANK_W-1:0] wrap_rom(
        input logic [ROM_BANK_W-1:0]  bank,
        input logic [ROM_COUNT_W-1:0] n
    );
        logic [ROM_COUNT_W-1:0] mask;
        mask = n - 1'b1;
        if ({1'b0, bank} >= n) begin
            wrap_rom = bank & mask[ROM_BANK_W-1:0];
        end else begin
            wrap_rom = bank;
        end
    endfunction

    // Returns {valid, bank}. Without cartridge RAM the bank becomes invalid.
    function automatic logic [RAM_BANK_W:0] sel_ram(
        input logic [RAM_BANK_W-1:0]  v,
        input logic [RAM_COUNT_W-1:0] n
    );
        logic [RAM_COUNT_W-1:0] mask;
        mask = n - 1'b1;
        if (n == '0) begin
            sel_ram = '0;
        end else if ({1'b0, v} >= n) begin
            sel_ram = {1'b1, v & mask[RAM_BANK_W-1:0]};
        end else begin
            sel_ram = {1'b1, v};
        end
    endfunction

    always_comb begin
        logic [RAM_BANK_W:0]   sel;
        logic [4:0]            low5;
        logic [3:0]            low4;
        logic [ROM_BANK_W-1:0] t;
        logic [1:0]            ub;
        logic                  nib_en;

        n_state = r_state;
        sel     = '0;
        low5    = i_write_data[4:0];
        low4    = i_write_data[3:0];
        t       = '0;
        ub      = i_write_data[1:0];
        nib_en  = (i_write_data[3:0] == 4'hA);

        if (i_command == CMD_WRITE && !i_cpu_address[15]) begin
            case (i_mapper_kind)
                KIND_FIRST: begin
                    case (i_cpu_address[14:13])
                        2'd0: begin
                            if (w_ram_n != '0) begin
                                n_state.ram_enabled = nib_en;
                            end
                        end
                        2'd1: begin
                            if (low5 == '0) begin
                                low5 = 5'd1;
                            end
                            n_state.rom_bank = wrap_rom({r_state.rom_bank[8:5], low5}, w_rom_n);
                        end
                        2'd2: begin
                            n_state.upper_bits = ub;
                            n_state.rom_bank = wrap_rom({2'b00, ub, r_state.rom_bank[4:0]},
                                                        w_rom_n);
                            if (!r_state.rom_mode) begin
                                sel = (w_ram_n == RAM_COUNT_W'(1)) ? {1'b1, 4'd0} :
                                      sel_ram({2'b00, ub}, w_ram_n);
                                n_state.ram_bank_valid = sel[RAM_BANK_W];
                                n_state.ram_bank       = sel[RAM_BANK_W-1:0];
                            end
                        end
                        default: begin
                            n_state.rom_mode = !i_write_data[0];
                            if (!i_write_data[0]) begin
                                n_state.ram_bank       = '0;
                                n_state.ram_bank_valid = 1'b1;
                            end else begin
                                sel = (w_ram_n == RAM_COUNT_W'(1)) ? {1'b1, 4'd0} :
                                      sel_ram({2'b00, r_state.upper_bits}, w_ram_n);
                                n_state.ram_bank_valid = sel[RAM_BANK_W];
                                n_state.ram_bank       = sel[RAM_BANK_W-1:0];
                            end
                        end
                    endcase
                end
                KIND_SECOND: begin
                    if (!i_cpu_address[14]) begin
                        if (!i_cpu_address[8]) begin
                            if (w_ram_n != '0) begin
                                n_state.ram_enabled = nib_en;
                            end
                        end else begin
                            if (low4 == '0) begin
                                low4 = 4'd1;
                            end
                            n_state.rom_bank = wrap_rom({5'b0, low4}, w_rom_n);
                        end
                    end
                end
                KIND_THIRD: begin
                    case (i_cpu_address[14:13])
                        2'd0: begin
                            if (w_ram_n != '0) begin
                                n_state.ram_enabled = nib_en;
                            end
                        end
                        2'd1: begin
                            t = wrap_rom({2'b00, i_write_data[6:0]}, w_rom_n);
                            n_state.rom_bank = (t == '0) ? ROM_BANK_W'(1) : t;
                        end
                        2'd2: begin
                            // Values above 3 select clock registers, which are not present.
                            if (i_write_data > 8'd3) begin
                                n_state.ram_bank       = '0;
                                n_state.ram_bank_valid = 1'b0;
                            end else begin
                                sel = sel_ram({2'b00, ub}, w_ram_n);
                                n_state.ram_bank_valid = sel[RAM_BANK_W];
                                n_state.ram_bank       = sel[RAM_BANK_W-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    case (i_cpu_address[14:13])
                        2'd0: begin
                            if (w_ram_n != '0) begin
                                n_state.ram_enabled = (i_write_data == 8'h0A);
                            end
                        end
                        2'd1: begin
                            if (!i_cpu_address[12]) begin
                                n_state.rom_bank = wrap_rom({r_state.rom_bank[8], i_write_data},
                                                            w_rom_n);
                            end else begin
                                n_state.rom_bank = wrap_rom({i_write_data[0],
                                                             r_state.rom_bank[7:0]}, w_rom_n);
                            end
                        end
                        2'd2: begin
                            sel = sel_ram(low4, w_ram_n);
                            n_state.ram_bank_valid = sel[RAM_BANK_W];
                            n_state.ram_bank       = sel[RAM_BANK_W-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.rom_bank       <= ROM_BANK_W'(1);
            r_state.ram_bank       <= '0;
            r_state.ram_bank_valid <= 1'b1;
            r_state.ram_enabled    <= 1'b0;
            r_state.rom_mode       <= 1'b1;
            r_state.upper_bits     <= '0;
        end else if (i_update) begin
            r_state <= n_state;
        end
    end

    assign o_state         = r_state;
    assign o_rom_bank_next = n_state.rom_bank;

endmodule

FILE: hdl/cbm_xlate.sv
// Read address translation from CPU address to ROM or cartridge RAM offset.
module cbm_xlate (
    input  logic [1:0]                      i_mapper_kind,
    input  cbm_pkg::t_bank_state            i_state,
    input  logic                            i_command,
    input  logic [cbm_pkg::ADDR_W-1:0]      i_cpu_address,
    output logic [1:0]                      o_target,
    output logic [cbm_pkg::OFFSET_W-1:0]    o_physical_offset
);
    import cbm_pkg::*;

    always_comb begin
        logic [ROM_BANK_W-1:0] bank0;

        o_target          = TGT_NONE;
        o_physical_offset = '0;
        // The first kind in RAM banking mode maps the lower area through the
        // upper ROM bank bits.
        bank0 = (i_mapper_kind == KIND_FIRST && !i_state.rom_mode) ?
                {i_state.rom_bank[8:5], 5'b0} : '0;

        if (i_command == CMD_READ) begin
            if (i_cpu_address[15:14] == 2'b00) begin
                o_target          = TGT_ROM;
                o_physical_offset = {bank0, i_cpu_address[13:0]};
            end else if (i_cpu_address[15:14] == 2'b01) begin
                o_target          = TGT_ROM;
                o_physical_offset = {i_state.rom_bank, i_cpu_address[13:0]};
            end else if (i_cpu_address[15:13] == 3'b101) begin
                if (i_state.ram_enabled && i_state.ram_bank_valid &&
                    i_mapper_kind != KIND_SECOND) begin
                    o_target          = TGT_RAM;
                    o_physical_offset = OFFSET_W'({i_state.ram_bank, i_cpu_address[12:0]});
                end
            end
        end
    end

endmodule

FILE: hdl/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: channels, configuration and pipeline registers.
//
// Usage: items arrive on the input channel (i_in_valid / o_in_ready) with a
// command, a CPU address and a write byte. A write access updates the banking
// registers of the selected mapper kind; a read access is translated to a ROM
// or cartridge RAM byte offset. Every item gives exactly one result on the
// output channel (o_out_valid / i_out_ready): target, offset and the upper
// ROM bank as it stands after the item.
// An accepted item is held in an input register, goes through the write
// decode and translation logic and lands in the result register once that
// register is free or being emptied. One item is taken per cycle while the
// receiver keeps up; the input side keeps accepting while a result waits,
// as long as the input register is empty or its item moves on to the result
// register, which is free or being emptied in the same cycle.
// When the receiver stalls, the result register and then the input register
// hold, and o_in_ready falls once both are full.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_wdata) are registered
// and are to be made while no item is in flight; the block does not enforce
// this. Reset sets the first mapper kind, two ROM banks, no RAM, ROM bank 1
// and ROM banking mode, and empties both registers.
module cartridge_bank_mapper #(
    parameter int MAX_ROM_BANKS = cbm_pkg::DEF_MAX_ROM_BANKS,
    parameter int MAX_RAM_BANKS = cbm_pkg::DEF_MAX_RAM_BANKS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [cbm_pkg::ADDR_W-1:0]         i_cpu_address,
    input  logic [cbm_pkg::DATA_W-1:0]         i_write_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_target,
    output logic [cbm_pkg::OFFSET_W-1:0]       o_physical_offset,
    output logic [cbm_pkg::ROM_BANK_W-1:0]     o_rom_bank_now
);
    import cbm_pkg::*;

    logic [1:0]             r_mapper_kind;
    logic [ROM_COUNT_W-1:0] r_rom_bank_count;
    logic [RAM_COUNT_W-1:0] r_ram_bank_count;

    logic                   r_in_valid;
    logic                   r_in_command;
    logic [ADDR_W-1:0]      r_in_address;
    logic [DATA_W-1:0]      r_in_data;

    logic                   r_out_valid;
    logic [1:0]             r_out_target;
    logic [OFFSET_W-1:0]    r_out_offset;
    logic [ROM_BANK_W-1:0]  r_out_rom_bank;

    logic                   w_advance;
    logic                   w_in_take;
    t_bank_state            w_state;
    logic [ROM_BANK_W-1:0]  w_rom_bank_next;
    logic [1:0]             w_target;
    logic [OFFSET_W-1:0]    w_offset;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper_kind    <= KIND_FIRST;
            r_rom_bank_count <= ROM_COUNT_W'(2);
            r_ram_bank_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAPPER_KIND:    r_mapper_kind    <= i_cfg_wdata[1:0];
                CFG_ROM_BANK_COUNT: r_rom_bank_count <= i_cfg_wdata[ROM_COUNT_W-1:0];
                CFG_RAM_BANK_COUNT: r_ram_bank_count <= i_cfg_wdata[RAM_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_command <= i_command;
            r_in_address <= i_cpu_address;
            r_in_data    <= i_write_data;
        end
    end

    cbm_state #(
        .MAX_ROM_BANKS (MAX_ROM_BANKS),
        .MAX_RAM_BANKS (MAX_RAM_BANKS)
    ) u_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mapper_kind    (r_mapper_kind),
        .i_rom_bank_count (r_rom_bank_count),
        .i_ram_bank_count (r_ram_bank_count),
        .i_update         (w_advance),
        .i_command        (r_in_command),
        .i_cpu_address    (r_in_address),
        .i_write_data     (r_in_data),
        .o_state          (w_state),
        .o_rom_bank_next  (w_rom_bank_next)
    );

    cbm_xlate u_xlate (
        .i_mapper_kind     (r_mapper_kind),
        .i_state           (w_state),
        .i_command         (r_in_command),
        .i_cpu_address     (r_in_address),
        .o_target          (w_target),
        .o_physical_offset (w_offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_target   <= w_target;
            r_out_offset   <= w_offset;
            r_out_rom_bank <= w_rom_bank_next;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_target          = r_out_target;
    assign o_physical_offset = r_out_offset;
    assign o_rom_bank_now    = r_out_rom_bank;

    // A waiting result always reports the ROM bank that the state holds.
    a_bank_now_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_rom_bank == w_state.rom_bank))
        else $error("result ROM bank differs from the bank state");

    // Read items never change the banking state.
    a_read_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_command == CMD_READ) |=> (w_state == $past(w_state)))
        else $error("read item changed the banking state");

    // Write items give an empty result.
    a_write_result_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_command == CMD_WRITE) |=>
        (r_out_target == TGT_NONE && r_out_offset == '0))
        else $error("write item produced a translation");

    // A RAM target needs RAM enabled and a valid bank.
    a_ram_target_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_target == TGT_RAM) |->
        (w_state.ram_enabled && w_state.ram_bank_valid))
        else $error("RAM target without enabled valid RAM bank");

endmodule
